[rtl/core/cci_pkg.sv]
package cci_pkg;

  // Geometry of the segment and of one block.
  localparam int BLOCK_BYTES   = 4096;
  localparam int SEGMENT_BYTES = 262144;
  localparam int MAX_ENTRIES   = 64;
  localparam int SEG_BLOCKS    = SEGMENT_BYTES / BLOCK_BYTES;
  localparam int QUEUE_DEPTH   = 2;

  // Field and state widths.
  localparam int BLK_W    = $clog2(BLOCK_BYTES);
  localparam int POS_W    = 19;
  localparam int SUM_W    = POS_W + 1;
  localparam int END_W    = SUM_W - BLK_W;
  localparam int MARGIN_W = 12;
  localparam int PROD_W   = 13;
  localparam int OBC_W    = 7;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int TYPE_W   = 2;
  localparam int ERR_W    = 2;

  // Cluster type codes.
  localparam logic [TYPE_W-1:0] CT_PLAIN   = 2'd0;
  localparam logic [TYPE_W-1:0] CT_HEAD    = 2'd1;
  localparam logic [TYPE_W-1:0] CT_NONHEAD = 2'd2;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_COMP  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

  // One classified span, handed from the front to the back.
  typedef struct packed {
    logic [ERR_W-1:0] err;
    logic             plain;
    logic [BLK_W-1:0] offset;
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] cross_cnt;
    logic [IDX_W-1:0] obc;
    logic [POS_W-1:0] span;
  } span_desc_t;

endpackage

[rtl/core/cci_front.sv]
module cci_front
  import cci_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_segment_start,
  input  logic [POS_W-1:0]    in_remaining_bytes,
  input  logic [POS_W-1:0]    in_consumed_bytes,
  input  logic [PROD_W-1:0]   in_produced_bytes,
  input  logic [MARGIN_W-1:0] ratio_margin,
  output logic                push_valid,
  input  logic                push_ready,
  output span_desc_t          push_desc
);

  logic                hold_v_r;
  logic                seg_r;
  logic [POS_W-1:0]    rem_r;
  logic [POS_W-1:0]    cons_r;
  logic [PROD_W-1:0]   prod_r;
  logic [POS_W-1:0]    pos_r;
  logic [OBC_W-1:0]    obc_r;

  logic                fire;
  logic [POS_W-1:0]    pos;
  logic [OBC_W-1:0]    obc;
  logic                big;
  logic                comp_fail;
  logic                ratio_low;
  logic                plain;
  logic [BLK_W:0]      plain_len;
  logic [SUM_W-1:0]    sum_raw;
  logic [SUM_W-1:0]    end_sum;
  logic [SUM_W-1:0]    span_full;
  logic [END_W-1:0]    end_blk;
  logic [END_W-1:0]    start_blk;
  logic [END_W-1:0]    count_full;
  logic [END_W-1:0]    cross_full;
  logic                err_range;
  logic [ERR_W-1:0]    err;

  assign fire     = hold_v_r && push_ready;
  assign in_ready = !hold_v_r || push_ready;

  always_comb begin
    pos       = seg_r ? '0 : pos_r;
    obc       = seg_r ? '0 : obc_r;
    big       = rem_r > POS_W'(BLOCK_BYTES);
    comp_fail = big && (prod_r == '0);
    ratio_low = SUM_W'(cons_r) < (SUM_W'(prod_r) + SUM_W'(ratio_margin));
    plain     = !big || ratio_low;
    plain_len = (BLK_W+1)'(BLOCK_BYTES) - {1'b0, pos[BLK_W-1:0]};

    if (!big) begin
      sum_raw = SUM_W'(pos) + SUM_W'(rem_r);
    end else if (ratio_low) begin
      sum_raw = SUM_W'(pos) + SUM_W'(plain_len);
    end else begin
      sum_raw = SUM_W'(pos) + SUM_W'(cons_r);
    end

    // A compressed span whose tail past the last boundary is within the
    // margin is cut back to that boundary.
    if (!plain && (SUM_W'(sum_raw[BLK_W-1:0]) <= SUM_W'(ratio_margin))) begin
      end_sum = {sum_raw[SUM_W-1:BLK_W], {BLK_W{1'b0}}};
    end else begin
      end_sum = sum_raw;
    end

    span_full  = end_sum - SUM_W'(pos);
    end_blk    = end_sum[SUM_W-1:BLK_W];
    start_blk  = END_W'(pos[POS_W-1:BLK_W]);
    count_full = end_blk - start_blk;
    cross_full = count_full + END_W'(end_sum[BLK_W-1:0] != '0);
    err_range  = (end_blk <= start_blk) || (count_full > END_W'(MAX_ENTRIES)) ||
                 (end_blk > END_W'(SEG_BLOCKS));

    if (comp_fail) begin
      err = ERR_COMP;
    end else if (err_range) begin
      err = ERR_RANGE;
    end else begin
      err = ERR_NONE;
    end

    push_desc.err       = err;
    push_desc.plain     = plain;
    push_desc.offset    = pos[BLK_W-1:0];
    push_desc.start     = pos[BLK_W+IDX_W-1:BLK_W];
    push_desc.count     = count_full[CNT_W-1:0];
    push_desc.cross_cnt = cross_full[CNT_W-1:0];
    push_desc.obc       = obc[IDX_W-1:0];
    push_desc.span      = span_full[POS_W-1:0];
  end

  assign push_valid = hold_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      pos_r    <= '0;
      obc_r    <= '0;
    end else begin
      if (in_valid && in_ready) begin
        hold_v_r <= 1'b1;
      end else if (fire) begin
        hold_v_r <= 1'b0;
      end
      // A failed span keeps the position, but a segment start still clears it.
      if (fire) begin
        if (err == ERR_NONE) begin
          pos_r <= end_sum[POS_W-1:0];
          obc_r <= obc + OBC_W'(1);
        end else begin
          pos_r <= pos;
          obc_r <= obc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      seg_r  <= in_segment_start;
      rem_r  <= in_remaining_bytes;
      cons_r <= in_consumed_bytes;
      prod_r <= in_produced_bytes;
    end
  end

endmodule

[rtl/core/cci_queue.sv]
module cci_queue
  import cci_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  span_desc_t wr_desc,
  output logic       rd_valid,
  input  logic       rd_ready,
  output span_desc_t rd_desc
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  span_desc_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W:0]     fill_r;
  logic               do_wr;
  logic               do_rd;

  assign wr_ready = fill_r != (PTR_W+1)'(QUEUE_DEPTH);
  assign rd_valid = fill_r != '0;
  assign rd_desc  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill_r <= fill_r + (PTR_W+1)'(1);
      end else if (do_rd && !do_wr) begin
        fill_r <= fill_r - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

[rtl/core/cci_back.sv]
module cci_back
  import cci_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  span_desc_t        pop_desc,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TYPE_W-1:0] out_cluster_type,
  output logic [BLK_W-1:0]  out_cluster_offset,
  output logic [IDX_W-1:0]  out_delta_back,
  output logic [CNT_W-1:0]  out_delta_forward,
  output logic [IDX_W-1:0]  out_block_index,
  output logic [IDX_W-1:0]  out_entry_index,
  output logic [POS_W-1:0]  out_span_bytes,
  output logic              out_last,
  output logic [ERR_W-1:0]  out_error
);

  logic              busy_r;
  span_desc_t        d_r;
  logic [IDX_W-1:0]  back_r;
  logic              out_valid_r;
  logic [TYPE_W-1:0] type_r;
  logic [BLK_W-1:0]  ofs_r;
  logic [IDX_W-1:0]  dback_r;
  logic [CNT_W-1:0]  dfwd_r;
  logic [IDX_W-1:0]  blk_r;
  logic [IDX_W-1:0]  ent_r;
  logic [POS_W-1:0]  span_r;
  logic              last_r;
  logic [ERR_W-1:0]  err_r;

  logic              slot_free;
  logic              emit;
  logic              is_err;
  logic              is_last;
  logic [TYPE_W-1:0] ctype;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = busy_r && slot_free;
  assign pop_ready = !busy_r;
  assign is_err    = d_r.err != ERR_NONE;
  assign is_last   = is_err || ((CNT_W'(back_r) + CNT_W'(1)) == d_r.count);

  always_comb begin
    if (d_r.plain) begin
      ctype = CT_PLAIN;
    end else if (back_r == '0) begin
      ctype = CT_HEAD;
    end else begin
      ctype = CT_NONHEAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!busy_r && pop_valid) begin
        busy_r <= 1'b1;
      end else if (emit && is_last) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && pop_valid) begin
      d_r    <= pop_desc;
      back_r <= '0;
    end else if (emit) begin
      back_r <= back_r + IDX_W'(1);
    end
    if (emit) begin
      last_r <= is_last;
      err_r  <= d_r.err;
      if (is_err) begin
        type_r  <= '0;
        ofs_r   <= '0;
        dback_r <= '0;
        dfwd_r  <= '0;
        blk_r   <= '0;
        ent_r   <= '0;
        span_r  <= '0;
      end else begin
        type_r  <= ctype;
        ofs_r   <= d_r.offset;
        dback_r <= back_r;
        dfwd_r  <= d_r.cross_cnt - CNT_W'(back_r) - CNT_W'(1);
        blk_r   <= d_r.obc;
        ent_r   <= d_r.start + back_r;
        span_r  <= d_r.span;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cluster_type   = type_r;
  assign out_cluster_offset = ofs_r;
  assign out_delta_back     = dback_r;
  assign out_delta_forward  = dfwd_r;
  assign out_block_index    = blk_r;
  assign out_entry_index    = ent_r;
  assign out_span_bytes     = span_r;
  assign out_last           = last_r;
  assign out_error          = err_r;

endmodule

[rtl/core/compressed_cluster_indexer.sv]
// Channel | Direction | Ports                                   | Word
// in_     | input     | in_valid / in_ready + four span fields  | one compressor span result
// out_    | output    | out_valid / out_ready + nine fields     | one cluster index entry
// cfg_    | input     | cfg_valid / cfg_ready, cfg_ratio_margin | the ratio margin register
//
// The front takes one span word and classifies it in the following cycle; it can
// take a word every cycle while the two-entry queue has room.
// The back loads a span and then sends one entry word per cycle while the output
// register is free, and takes no new span until its last word; an error span gives one word.
// Reset (synchronous, rst_n low) clears the margin, the segment position, the
// output block count, the queue and all valid flags.
// Either side may stall: the queue and the output register let the front and
// the back wait independently, and a held output word does not block the front while the queue has room.
module compressed_cluster_indexer
  import cci_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_segment_start,
  input  logic [POS_W-1:0]    in_remaining_bytes,
  input  logic [POS_W-1:0]    in_consumed_bytes,
  input  logic [PROD_W-1:0]   in_produced_bytes,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TYPE_W-1:0]   out_cluster_type,
  output logic [BLK_W-1:0]    out_cluster_offset,
  output logic [IDX_W-1:0]    out_delta_back,
  output logic [CNT_W-1:0]    out_delta_forward,
  output logic [IDX_W-1:0]    out_block_index,
  output logic [IDX_W-1:0]    out_entry_index,
  output logic [POS_W-1:0]    out_span_bytes,
  output logic                out_last,
  output logic [ERR_W-1:0]    out_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [MARGIN_W-1:0] cfg_ratio_margin
);

  // The margin register is always ready to be written; the user must write it only
  // while the block is idle, and the block itself does not enforce this.
  logic [MARGIN_W-1:0] margin_r;

  logic       push_valid;
  logic       push_ready;
  span_desc_t push_desc;
  logic       pop_valid;
  logic       pop_ready;
  span_desc_t pop_desc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      margin_r <= cfg_ratio_margin;
    end
  end

  // Front: holds the segment position and output block count, decides how
  // many bytes each span takes and how many block entries it produces.
  cci_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_segment_start   (in_segment_start),
    .in_remaining_bytes (in_remaining_bytes),
    .in_consumed_bytes  (in_consumed_bytes),
    .in_produced_bytes  (in_produced_bytes),
    .ratio_margin       (margin_r),
    .push_valid         (push_valid),
    .push_ready         (push_ready),
    .push_desc          (push_desc)
  );

  // Short queue of classified spans between the two halves.
  cci_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_desc  (push_desc),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_desc  (pop_desc)
  );

  // Back: walks the blocks of one span and sends an index entry for each, or one error entry for a failed span.
  cci_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_desc           (pop_desc),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cluster_type   (out_cluster_type),
    .out_cluster_offset (out_cluster_offset),
    .out_delta_back     (out_delta_back),
    .out_delta_forward  (out_delta_forward),
    .out_block_index    (out_block_index),
    .out_entry_index    (out_entry_index),
    .out_span_bytes     (out_span_bytes),
    .out_last           (out_last),
    .out_error          (out_error)
  );

endmodule
